FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/msqt_pkg.sv
// ----------------------------------------------------------------------------
// msqt_pkg: shared types and constants
// Entry, query and evaluator types and the command codes of the query table.
// ----------------------------------------------------------------------------
package msqt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TEAM_COUNT  = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_NEAREST = 3'd2;
  localparam logic [2:0] KIND_RADIUS  = 3'd3;
  localparam logic [2:0] KIND_BOX     = 3'd4;

  localparam logic [30:0] SQ_CEIL     = 31'h7FFF_FFFF;
  localparam logic [30:0] LIMIT_RESET = 31'h7FFE_0000;

  typedef struct packed {
    logic               used;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [2:0]         team;
    logic [15:0]        id;
  } entry_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] lox;
    logic signed [31:0] hix;
    logic signed [31:0] loy;
    logic signed [31:0] hiy;
    logic [15:0]        uid;
    logic               ign;
    logic [7:0]         mask;
  } query_t;

  typedef struct packed {
    logic        valid;
    logic        pass;
    logic        inbox;
    logic [30:0] dsq;
    logic [15:0] id;
  } eval_t;

  typedef struct packed {
    logic        pass;
    logic        inbox;
    logic [15:0] id;
  } tag_t;

endpackage

FILE: src/masked_spatial_query_table_core.sv
// ----------------------------------------------------------------------------
// masked_spatial_query_table_core: masked 2D nearest / radius / box table
// Table of up to 64 positioned, team-tagged entries held in a ring of cells.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the s_ channel (kind in s_tuser), and
// results leave as beats on the m_ channel; m_tlast marks the final result
// beat of a command. The cfg channel writes the nearest-search ceiling and is
// always ready; write it only while the block is idle.
// Insert: the entry is loaded straight into the first free cell and the
// result beat appears on the next cycle. Remove and the three queries
// rotate the whole cell ring once, one entry per cycle unless the output
// stalls, and each entry passing the head feeds a five-stage distance
// pipeline. A new command is taken only once the previous one has produced
// its last beat. Remove closes the gap during the same rotation, so
// insertion order stays. When the receiver stalls, the ring and pipeline
// freeze with the output register until the waiting beat is taken; nothing
// is lost or repeated. Reset empties the table, zeroes the id counter and
// restores the ceiling.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module masked_spatial_query_table_core (
  input  logic         clk,
  input  logic         rst,
  // s_tdata: pos_x[31:0], pos_y[63:32], corner_x[95:64], corner_y[127:96],
  // radius[158:128], unit_id[174:159], ignore_valid[175], team[178:176],
  // team_mask[186:179], zero fill[191:187]
  input  logic [191:0] s_tdata,
  // s_tuser: kind[2:0]
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // m_tdata: result_id[15:0]
  output logic [15:0]  m_tdata,
  // m_tuser: found[0], table_full[1]
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic [30:0]  cfg_data,
  input  logic         cfg_valid,
  output logic         cfg_ready
);

  localparam int N = msqt_pkg::TABLE_DEPTH;
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                 state;
  logic [msqt_pkg::IDX_W-1:0] step;
  logic [msqt_pkg::CNT_W-1:0] count;
  logic [15:0]                next_ident;
  logic [30:0]                nearest_limit;
  logic [2:0]                 q_kind;
  msqt_pkg::query_t           q;
  logic [30:0]                q_lim;
  logic                       dropped;
  logic [30:0]                best;
  logic [15:0]                best_id;
  logic                       hit;
  logic                       pend_valid;
  logic [15:0]                pend_id;

  msqt_pkg::entry_t cells [N];
  msqt_pkg::entry_t tail_in;
  msqt_pkg::entry_t new_entry;
  msqt_pkg::eval_t  ev;
  logic             busy;

  logic        out_free, adv, in_acc, scan_step, last_step;
  logic        hit_now, take_next, list_match, near_upd, final_emit, do_insert;
  logic [2:0]  in_kind;
  logic signed [31:0] in_px, in_py, in_cx, in_cy;
  logic [30:0] in_r;
  logic [47:0] r_prod;
  logic [31:0] r_sq;

  assign in_kind  = s_tuser;
  assign in_px    = s_tdata[31:0];
  assign in_py    = s_tdata[63:32];
  assign in_cx    = s_tdata[95:64];
  assign in_cy    = s_tdata[127:96];
  assign in_r     = s_tdata[158:128];
  assign r_prod   = 48'(in_r[23:0]) * 48'(in_r[23:0]);
  assign r_sq     = r_prod[47:16];

  assign out_free  = !m_tvalid || m_tready;
  assign adv       = out_free;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign do_insert = in_acc && in_kind == msqt_pkg::KIND_INSERT &&
                     count != msqt_pkg::CNT_W'(N);

  assign scan_step = (state == ST_SCAN) && adv;
  assign last_step = step == msqt_pkg::IDX_W'(N - 1);

  // Remove: once the victim reaches the head, the tail is fed from the
  // second cell so every later entry moves down one slot; the last slot
  // fed in that mode is emptied.
  assign hit_now   = (q_kind == msqt_pkg::KIND_REMOVE) && !dropped &&
                     cells[0].used && cells[0].id == q.uid;
  assign take_next = dropped || hit_now;

  always_comb begin
    tail_in = cells[0];
    if (take_next) begin
      if (last_step) begin
        tail_in.used = 1'b0;
      end else begin
        tail_in = cells[1];
      end
    end
  end

  assign new_entry = '{used: 1'b1, x: in_px, y: in_py, team: s_tdata[178:176],
                       id: next_ident};

  for (genvar i = 0; i < N; i++) begin : g_cell
    msqt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (scan_step),
      .nbr        ((i == N - 1) ? tail_in : cells[(i + 1) % N]),
      .load       (do_insert && count == msqt_pkg::CNT_W'(i)),
      .load_entry (new_entry),
      .entry      (cells[i])
    );
  end

  msqt_eval u_eval (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (scan_step),
    .head     (cells[0]),
    .q        (q),
    .res      (ev),
    .busy     (busy)
  );

  assign list_match = adv && ev.valid && ev.pass &&
                      ((q_kind == msqt_pkg::KIND_RADIUS && ev.dsq < q_lim) ||
                       (q_kind == msqt_pkg::KIND_BOX && ev.inbox));
  assign near_upd   = adv && ev.valid && ev.pass &&
                      q_kind == msqt_pkg::KIND_NEAREST && ev.dsq < best;
  assign final_emit = (state == ST_DRAIN) && !busy && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      count         <= '0;
      next_ident    <= '0;
      nearest_limit <= msqt_pkg::LIMIT_RESET;
      dropped       <= 1'b0;
      hit           <= 1'b0;
      pend_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        nearest_limit <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_kind == msqt_pkg::KIND_INSERT) begin
              m_tvalid <= 1'b1;
              if (do_insert) begin
                count      <= count + msqt_pkg::CNT_W'(1);
                next_ident <= next_ident + 16'd1;
              end
            end else if (in_kind == msqt_pkg::KIND_REMOVE ||
                         in_kind == msqt_pkg::KIND_NEAREST ||
                         in_kind == msqt_pkg::KIND_RADIUS ||
                         in_kind == msqt_pkg::KIND_BOX) begin
              state      <= ST_SCAN;
              step       <= '0;
              dropped    <= 1'b0;
              hit        <= 1'b0;
              pend_valid <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_step) begin
            step <= step + msqt_pkg::IDX_W'(1);
            if (hit_now) begin
              dropped <= 1'b1;
            end
            if (last_step) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (final_emit) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
            dropped  <= 1'b0;
            if (dropped) begin
              count <= count - msqt_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (list_match) begin
        pend_valid <= 1'b1;
        if (pend_valid) begin
          m_tvalid <= 1'b1;
        end
      end
      if (near_upd) begin
        hit <= 1'b1;
      end
    end
  end

  // Query registers and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_kind <= in_kind;
      q.px   <= in_px;
      q.py   <= in_py;
      q.lox  <= (in_px < in_cx) ? in_px : in_cx;
      q.hix  <= (in_px < in_cx) ? in_cx : in_px;
      q.loy  <= (in_py < in_cy) ? in_py : in_cy;
      q.hiy  <= (in_py < in_cy) ? in_cy : in_py;
      q.uid  <= s_tdata[174:159];
      q.ign  <= s_tdata[175];
      q.mask <= s_tdata[186:179];
      q_lim  <= (|in_r[30:24] || r_sq[31]) ? msqt_pkg::SQ_CEIL : r_sq[30:0];
      best   <= nearest_limit;
      if (in_kind == msqt_pkg::KIND_INSERT) begin
        m_tlast <= 1'b1;
        if (do_insert) begin
          m_tdata <= next_ident;
          m_tuser <= 2'b01;
        end else begin
          m_tdata <= 16'd0;
          m_tuser <= 2'b10;
        end
      end
    end
    if (near_upd) begin
      best    <= ev.dsq;
      best_id <= ev.id;
    end
    if (list_match) begin
      pend_id <= ev.id;
      if (pend_valid) begin
        m_tdata <= pend_id;
        m_tuser <= 2'b01;
        m_tlast <= 1'b0;
      end
    end
    if (final_emit) begin
      m_tlast <= 1'b1;
      if (q_kind == msqt_pkg::KIND_REMOVE) begin
        m_tdata <= dropped ? q.uid : 16'd0;
        m_tuser <= {1'b0, dropped};
      end else if (q_kind == msqt_pkg::KIND_NEAREST) begin
        m_tdata <= hit ? best_id : 16'd0;
        m_tuser <= {1'b0, hit};
      end else begin
        m_tdata <= pend_valid ? pend_id : 16'd0;
        m_tuser <= {1'b0, pend_valid};
      end
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= msqt_pkg::CNT_W'(N),
                  "live count beyond table depth")
  `ASSERT_IMPLIES(a_nohit_last, clk, rst, m_tvalid && !m_tuser[0], m_tlast,
                  "not-found beat without last")
  `ASSERT_IMPLIES(a_drop_remove, clk, rst, dropped, q_kind == msqt_pkg::KIND_REMOVE,
                  "entry dropped outside a remove")

endmodule

FILE: src/msqt_cell.sv
// ----------------------------------------------------------------------------
// msqt_cell: one table slot
// Holds one entry; takes its neighbor's entry on a shift or a new one on load.
// ----------------------------------------------------------------------------
module msqt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  msqt_pkg::entry_t nbr,
  input  logic             load,
  input  msqt_pkg::entry_t load_entry,
  output msqt_pkg::entry_t entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.used <= 1'b0;
    end else if (shift) begin
      entry <= nbr;
    end else if (load) begin
      entry <= load_entry;
    end
  end

endmodule

FILE: src/msqt_eval.sv
// ----------------------------------------------------------------------------
// msqt_eval: distance and filter pipeline
// Five stages: difference, magnitude, x square, y square, saturating sum.
// ----------------------------------------------------------------------------
module msqt_eval (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  msqt_pkg::entry_t head,
  input  msqt_pkg::query_t q,
  output msqt_pkg::eval_t  res,
  output logic             busy
);

  logic [5:1]         v;
  msqt_pkg::tag_t     tag1, tag2, tag3, tag4;
  logic signed [32:0] dx1, dy1;
  logic [32:0]        ax, ay;
  logic               satx2, saty2, satx3, saty3, satx4, saty4;
  logic [23:0]        axl2, ayl2, ayl3;
  logic [47:0]        prodx, prody;
  logic [31:0]        sqx3, sqx4, sqy4;
  logic [32:0]        sum;
  logic               pass0;
  logic [30:0]        dsq5;
  logic               pass5, inbox5;
  logic [15:0]        id5;

  // Team filter and ignored id.
  assign pass0 = head.used && !(q.ign && head.id == q.uid) &&
                 (32'(head.team) < 32'(msqt_pkg::TEAM_COUNT)) && q.mask[head.team];

  assign ax    = dx1[32] ? 33'(-dx1) : 33'(dx1);
  assign ay    = dy1[32] ? 33'(-dy1) : 33'(dy1);
  assign prodx = 48'(axl2) * 48'(axl2);
  assign prody = 48'(ayl3) * 48'(ayl3);
  assign sum   = {1'b0, sqx4} + {1'b0, sqy4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1        <= {head.x[31], head.x} - {q.px[31], q.px};
      dy1        <= {head.y[31], head.y} - {q.py[31], q.py};
      tag1.pass  <= pass0;
      tag1.inbox <= (head.x > q.lox) && (head.x < q.hix) &&
                    (head.y > q.loy) && (head.y < q.hiy);
      tag1.id    <= head.id;

      satx2 <= |ax[32:24];
      saty2 <= |ay[32:24];
      axl2  <= ax[23:0];
      ayl2  <= ay[23:0];
      tag2  <= tag1;

      sqx3  <= prodx[47:16];
      satx3 <= satx2;
      saty3 <= saty2;
      ayl3  <= ayl2;
      tag3  <= tag2;

      sqy4  <= prody[47:16];
      sqx4  <= sqx3;
      satx4 <= satx3;
      saty4 <= saty3;
      tag4  <= tag3;

      dsq5   <= (satx4 || saty4 || sum > {2'b00, msqt_pkg::SQ_CEIL}) ?
                msqt_pkg::SQ_CEIL : sum[30:0];
      pass5  <= tag4.pass;
      inbox5 <= tag4.inbox;
      id5    <= tag4.id;
    end
  end

  assign res  = '{valid: v[5], pass: pass5, inbox: inbox5, dsq: dsq5, id: id5};
  assign busy = |v;

endmodule

FILE: tb/sv/msqt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msqt_checker: result predictor and scoreboard for the query table
// Watches the command, result and ceiling channels, keeps its own copy of the
// table, predicts every result beat and compares it with what the block sends.
// ----------------------------------------------------------------------------
module msqt_checker
  import msqt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [191:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         m_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [30:0]  cfg_data,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [15:0] id;
    logic        found;
    logic        full;
    logic        last;
  } beat_t;

  entry_t      tbl[$];
  beat_t       expected_beats[$];
  logic [15:0] id_counter;
  logic [30:0] ceiling;

  assign pending = expected_beats.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic queue_beat(input logic [15:0] id, input logic found,
                            input logic full, input logic last);
    beat_t b;
    b = '{id, found, full, last};
    expected_beats = {expected_beats, b};
  endtask

  function automatic logic [63:0] fix_square(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [63:0]        m;
    d = $signed({a[31], a}) - $signed({b[31], b});
    m = d[32] ? 64'(-d) : 64'(d);
    m = m & 64'h1_FFFF_FFFF;
    return (m * m) >> 16;
  endfunction

  function automatic logic [30:0] saturate(input logic [63:0] v);
    return (v > 64'(SQ_CEIL)) ? SQ_CEIL : v[30:0];
  endfunction

  function automatic logic team_ok(input entry_t e, input logic [15:0] uid,
                                   input logic ign, input logic [7:0] mask);
    if (ign && e.id == uid) return 1'b0;
    if (int'(e.team) >= TEAM_COUNT) return 1'b0;
    return mask[e.team];
  endfunction

  task automatic predict(input logic [2:0] kind, input logic [191:0] d);
    logic signed [31:0] px, py, cx, cy, lox, hix, loy, hiy;
    logic [30:0]        rad, lim, best, dsq;
    logic [63:0]        r64;
    logic [15:0]        uid, best_id;
    logic               ign, hit;
    logic [2:0]         team;
    logic [7:0]         mask;
    entry_t             e;
    int                 hits;
    px = d[31:0]; py = d[63:32]; cx = d[95:64]; cy = d[127:96];
    rad = d[158:128]; uid = d[174:159]; ign = d[175]; team = d[178:176];
    mask = d[186:179];
    hits = 0;
    case (kind)
      KIND_INSERT: begin
        if (tbl.size() >= TABLE_DEPTH) begin
          queue_beat(16'd0, 1'b0, 1'b1, 1'b1);
        end else begin
          e = '{1'b1, px, py, team, id_counter};
          tbl = {tbl, e};
          queue_beat(id_counter, 1'b1, 1'b0, 1'b1);
          id_counter++;
        end
      end
      KIND_REMOVE: begin
        hit = 1'b0;
        foreach (tbl[i]) begin
          if (!hit && tbl[i].id == uid) begin
            tbl.delete(i);
            hit = 1'b1;
            break;
          end
        end
        queue_beat(hit ? uid : 16'd0, hit, 1'b0, 1'b1);
      end
      KIND_NEAREST: begin
        best = ceiling; hit = 1'b0; best_id = '0;
        foreach (tbl[i]) begin
          dsq = saturate(fix_square(tbl[i].x, px) + fix_square(tbl[i].y, py));
          if (dsq < best && team_ok(tbl[i], uid, ign, mask)) begin
            best = dsq; best_id = tbl[i].id; hit = 1'b1;
          end
        end
        queue_beat(best_id, hit, 1'b0, 1'b1);
      end
      KIND_RADIUS, KIND_BOX: begin
        r64 = 64'(rad);
        lim = saturate((r64 * r64) >> 16);
        lox = (px < cx) ? px : cx; hix = (px < cx) ? cx : px;
        loy = (py < cy) ? py : cy; hiy = (py < cy) ? cy : py;
        foreach (tbl[i]) begin
          if (kind == KIND_RADIUS)
            hit = saturate(fix_square(tbl[i].x, px) + fix_square(tbl[i].y, py)) < lim;
          else
            hit = tbl[i].x > lox && tbl[i].x < hix && tbl[i].y > loy && tbl[i].y < hiy;
          if (hit && team_ok(tbl[i], uid, ign, mask)) begin
            queue_beat(tbl[i].id, 1'b1, 1'b0, 1'b0);
            hits++;
          end
        end
        if (hits == 0) queue_beat(16'd0, 1'b0, 1'b0, 1'b1);
        else expected_beats[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    id_counter = '0;
    ceiling = LIMIT_RESET;
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      tbl.delete();
      expected_beats.delete();
      id_counter = '0;
      ceiling = LIMIT_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          report("unexpected result beat, id", m_tdata, -1);
        end else begin
          want = expected_beats.pop_front();
          if (m_tdata !== want.id) report("result_id", m_tdata, want.id);
          if (m_tuser[0] !== want.found) report("found", m_tuser[0], want.found);
          if (m_tuser[1] !== want.full) report("table_full", m_tuser[1], want.full);
          if (m_tlast !== want.last) report("last", m_tlast, want.last);
        end
      end
      if (cfg_valid && cfg_ready) ceiling = cfg_data;
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the masked spatial query table
// Drives directed and random commands with random gaps on both channels,
// reprograms the nearest ceiling between phases, and reports the checker's
// outcome at the end of the run.
// ----------------------------------------------------------------------------
module tb;
  import msqt_pkg::*;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic [191:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [30:0]  cfg_data = '0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  int           fail_count;
  int           pending;

  // Idle percentages for the sender and the receiver; zero means no gaps.
  int           tx_idle = 25;
  int           rx_idle = 25;
  // Cycles the receiver still has to hold off during the backpressure test.
  int           hold_left = 0;
  // Number of inserts issued, used to aim removes and ignores at live ids.
  int           inserts_sent = 0;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE     = 32'sh0001_0000;

  always #1 clk = ~clk;

  masked_spatial_query_table_core u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  msqt_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: one ready decision per rising edge. A long hold, when one is
  // requested, keeps ready low so that the block's output and then its input
  // stall while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rst && ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Offers one command beat. The task returns at the edge where the beat is
  // taken and leaves valid high, so back-to-back beats never drop valid.
  // Ready is looked at on the falling edge, where it is stable.
  task automatic send_cmd(input logic [2:0] kind,
                          input logic signed [31:0] px, input logic signed [31:0] py,
                          input logic signed [31:0] cx, input logic signed [31:0] cy,
                          input logic [30:0] rad, input logic [15:0] uid,
                          input logic ign, input logic [2:0] team,
                          input logic [7:0] mask);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, mask, team, ign, uid, rad, cy, cx, py, px};
    if (kind == KIND_INSERT) inserts_sent++;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  // Writes the nearest ceiling once the block has drained. Unknown kinds
  // give no beat, so a margin of a full rotation is left before the write.
  task automatic write_ceiling(input logic [30:0] value);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coordinates are mostly near the origin so that queries find matches;
  // now and then a full-range value exercises every bit and saturation.
  function automatic logic signed [31:0] rand_pos();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(0, 200 << 16)) - (100 <<< 16);
  endfunction

  function automatic logic [30:0] rand_radius();
    if ($urandom_range(9) == 0) return 31'($urandom);
    return 31'($urandom_range(0, 80 << 16));
  endfunction

  function automatic logic [15:0] rand_id();
    return 16'($urandom_range(0, inserts_sent + 3));
  endfunction

  task automatic random_cmd();
    int roll;
    logic [7:0] mask;
    roll = $urandom_range(99);
    mask = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
    if (roll < 30)
      send_cmd(KIND_INSERT, rand_pos(), rand_pos(), $urandom, $urandom, 31'($urandom),
               16'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
    else if (roll < 50)
      send_cmd(KIND_REMOVE, $urandom, $urandom, $urandom, $urandom, 31'($urandom),
               rand_id(), 1'($urandom), 3'($urandom), 8'($urandom));
    else if (roll < 65)
      send_cmd(KIND_NEAREST, rand_pos(), rand_pos(), $urandom, $urandom, 31'($urandom),
               rand_id(), 1'($urandom), 3'($urandom), mask);
    else if (roll < 80)
      send_cmd(KIND_RADIUS, rand_pos(), rand_pos(), $urandom, $urandom, rand_radius(),
               rand_id(), 1'($urandom), 3'($urandom), mask);
    else if (roll < 96)
      send_cmd(KIND_BOX, rand_pos(), rand_pos(), rand_pos(), rand_pos(), 31'($urandom),
               rand_id(), 1'($urandom), 3'($urandom), mask);
    else
      send_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom,
               31'($urandom), 16'($urandom), 1'($urandom), 3'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: extreme positions, each command kind, filters, an absent
    // remove and the unknown kinds, which must produce nothing.
    send_cmd(KIND_INSERT, POS_MAX, POS_MAX, 0, 0, 0, 0, 0, 3'd7, 0);
    send_cmd(KIND_INSERT, POS_MIN, POS_MIN, 0, 0, 0, 0, 0, 3'd0, 0);
    send_cmd(KIND_INSERT, 0, 0, 0, 0, 0, 0, 0, 3'd3, 0);
    send_cmd(KIND_INSERT, ONE, ONE, 0, 0, 0, 0, 0, 3'd1, 0);
    send_cmd(KIND_INSERT, -ONE, ONE, 0, 0, 0, 0, 0, 3'd2, 0);
    send_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 16'd2, 1'b1, 0, 8'hFF);
    send_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00);
    send_cmd(KIND_NEAREST, POS_MIN, POS_MAX, 0, 0, 0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_RADIUS, 0, 0, 0, 0, 31'd0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_RADIUS, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 8'hFF);
    send_cmd(KIND_RADIUS, 0, 0, 0, 0, 31'(2 << 16), 16'd3, 1'b1, 0, 8'h0E);
    send_cmd(KIND_BOX, POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_BOX, 2 * ONE, 2 * ONE, -2 * ONE, -ONE, 0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_BOX, ONE, ONE, -ONE, -ONE, 0, 0, 0, 0, 8'hFF);
    send_cmd(KIND_REMOVE, 0, 0, 0, 0, 0, 16'd1, 0, 0, 0);
    send_cmd(KIND_REMOVE, 0, 0, 0, 0, 0, 16'd999, 0, 0, 0);
    send_cmd(3'd5, 0, 0, 0, 0, 0, 16'd0, 0, 0, 0);
    send_cmd(3'd6, 0, 0, 0, 0, 0, 16'd3, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 0, 16'd2, 0, 0, 0);
    send_cmd(KIND_NEAREST, ONE, ONE, 0, 0, 0, 0, 0, 0, 8'hFF);

    // Ceiling extremes: zero blocks every nearest hit, the maximum admits every unsaturated distance.
    write_ceiling(31'd0);
    send_cmd(KIND_NEAREST, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
    write_ceiling(31'h7FFF_FFFF);
    send_cmd(KIND_NEAREST, POS_MAX, POS_MIN, 0, 0, 0, 0, 0, 0, 8'hFF);
    write_ceiling(31'(4 << 16));

    // A stretch with no gaps on either side: fill the table to the top and
    // past it, so that refused inserts are seen.
    tx_idle = 0;
    rx_idle = 0;
    repeat (64) send_cmd(KIND_INSERT, rand_pos(), rand_pos(), 0, 0, 0, 0, 0,
                         3'($urandom), 0);

    // Backpressure: the receiver holds off while full-table radius lists are
    // offered back to back, so result beats pile up and the input stalls.
    hold_left = 400;
    repeat (4) send_cmd(KIND_RADIUS, 0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 8'hFF);
    tx_idle = 25;
    rx_idle = 25;

    // Random part, with the ceiling changed twice on the way.
    repeat (60) random_cmd();
    write_ceiling(31'($urandom));
    repeat (50) random_cmd();
    write_ceiling(31'($urandom_range(0, 2000 << 16)));
    repeat (50) random_cmd();

    // Drain and let the block settle before the verdict.
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
